/* sv/lhs_pkg.sv */
package lhs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int UW        = 31;
    localparam int AW        = 17;
    localparam int ACCW      = DW + 2;
    localparam int NUMW      = UW + FRAC_BITS + 1;
    localparam int CFGW      = 3;
    localparam int OUT_FW    = 3 * DW + 2 * UW;
    localparam int OUT_TW    = ((OUT_FW + 7) / 8) * 8;

    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [UW-1:0] RST_ONE  = UW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] RST_DAMP = AW'(1) << FRAC_BITS;
    localparam logic [UW-1:0] RST_STEP = UW'(655);

    typedef enum logic [CFGW-1:0] {
        CFG_SPRING = 3'd0,
        CFG_MASS   = 3'd1,
        CFG_DAMP   = 3'd2,
        CFG_NOISE  = 3'd3,
        CFG_STEP   = 3'd4,
        CFG_START  = 3'd5
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_BDT,
        OP_XV,
        OP_CD,
        OP_TF,
        OP_PN,
        OP_KX,
        OP_AF,
        OP_AV,
        OP_CI,
        OP_CN,
        OP_VV,
        OP_MK,
        OP_XX,
        OP_KP
    } t_op;

    typedef enum logic [1:0] {
        DV_CPN,
        DV_CVF,
        DV_CVN
    } t_div_sel;

    typedef struct packed {
        logic          done;
        logic          clip;
        logic [DW-1:0] quo;
    } t_div_res;

    function automatic logic f_ovf_acc(input logic signed [ACCW-1:0] v);
        return v[ACCW-1:DW-1] != {(ACCW-DW+1){v[DW-1]}};
    endfunction

    function automatic logic signed [DW-1:0] f_sat_acc(input logic signed [ACCW-1:0] v);
        logic signed [DW-1:0] r;
        if (f_ovf_acc(v)) begin
            r = v[ACCW-1] ? S_MIN : S_MAX;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/langevin_harmonic_step_top.sv */
// Channel   Direction  Transaction                 Fields (lowest bit up)
// s_axis    in         i_s_axis_tvalid/o_..tready  tdata: noise_sample; tuser: start_run
// m_axis    out        o_m_axis_tvalid/i_..tready  tdata: old_position, new_force,
//                                                  new_velocity, kinetic_energy,
//                                                  potential_energy; tuser: saturated
// cfg       in         i_cfg_we                    i_cfg_addr, i_cfg_data
//
// A step accepts a sample, runs 14 products through the one multiplier
// (multiply, then round/clip/accumulate), and loads the result.
// A step with start_run adds 3 divisions with Q16.16 quotients,
// done by the restoring divider giving one quotient bit per cycle.
// Reset is synchronous, active low; no clearing pass.
// A finished result waits in the output register; the next step is taken meanwhile
// and holds its result until that register is free.
module langevin_harmonic_step_top import lhs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFGW-1:0]   i_cfg_addr,
    input  logic [DW-1:0]     i_cfg_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DW-1:0]     i_s_axis_tdata,  // [31:0] noise_sample
    input  logic [0:0]        i_s_axis_tuser,  // [0] start_run
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_TW-1:0] o_m_axis_tdata,  // old_position, new_force, new_velocity,
                                               // kinetic_energy, potential_energy, zero pad
    output logic [0:0]        o_m_axis_tuser   // [0] saturated
);

    logic [UW-1:0] r_k;
    logic [UW-1:0] r_m;
    logic [AW-1:0] r_a;
    logic [UW-1:0] r_b;
    logic [UW-1:0] r_dt;
    logic [DW-1:0] r_x0;

    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_v;
    logic signed [DW-1:0] r_f;
    logic signed [DW-1:0] r_cpn;
    logic signed [DW-1:0] r_cvf;
    logic signed [DW-1:0] r_cvn;

    logic signed [DW-1:0]   r_noise;
    logic                   r_start;
    logic                   r_clip;
    logic signed [DW-1:0]   r_bdt;
    logic signed [DW-1:0]   r_tmp;
    logic signed [DW-1:0]   r_npos;
    logic signed [DW-1:0]   r_fnew;
    logic signed [DW-1:0]   r_nvel;
    logic signed [DW-1:0]   r_ke;
    logic signed [DW-1:0]   r_pe;
    logic signed [ACCW-1:0] r_acc;
    t_op                    r_op;
    t_div_sel               r_div_sel;

    logic              r_out_valid;
    logic [OUT_TW-1:0] r_out_data;
    logic              r_out_sat;

    t_state r_state;
    t_state n_state;

    logic s_accept;
    logic mul_en;
    logic div_start;
    logic out_load;

    logic signed [DW-1:0]   mul_a;
    logic signed [DW-1:0]   mul_b;
    logic                   mul_half;
    logic signed [DW-1:0]   mul_res;
    logic                   mul_clip;
    logic [UW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    t_div_res               div_res;
    logic signed [ACCW-1:0] acc_base;
    logic signed [ACCW-1:0] acc_sum;
    logic signed [ACCW-1:0] post_val;
    logic signed [DW-1:0]   post_sat;
    logic                   post_ovf;

    lhs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_half (mul_half),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_res  (mul_res),
        .o_clip (mul_clip)
    );

    lhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                priority if (r_op == OP_BDT && r_start) begin
                    n_state = ST_DIV_GO;
                end else if (r_op == OP_KP) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    n_state = (r_div_sel == DV_CVN) ? ST_MUL : ST_DIV_GO;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        mul_en          = (r_state == ST_MUL);
        div_start       = (r_state == ST_DIV_GO);
        out_load        = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // operand select per product
    always_comb begin
        mul_half = 1'b0;
        unique case (r_op)
            OP_BDT: begin mul_a = $signed(DW'(r_b));    mul_b = $signed(DW'(r_dt)); end
            OP_XV:  begin mul_a = r_bdt;                mul_b = r_v;                end
            OP_CD:  begin mul_a = r_cpn;                mul_b = $signed(DW'(r_dt)); end
            OP_TF:  begin mul_a = r_tmp;                mul_b = r_f;                end
            OP_PN:  begin mul_a = r_cpn;                mul_b = r_noise;            end
            OP_KX:  begin mul_a = $signed(DW'(r_k));    mul_b = r_npos;             end
            OP_AF:  begin mul_a = $signed(DW'(r_a));    mul_b = r_f;                end
            OP_AV:  begin mul_a = $signed(DW'(r_a));    mul_b = r_v;                end
            OP_CI:  begin mul_a = r_cvf;                mul_b = r_tmp;              end
            OP_CN:  begin mul_a = r_cvn;                mul_b = r_noise;            end
            OP_VV:  begin mul_a = r_nvel;               mul_b = r_nvel;             end
            OP_MK: begin
                mul_a    = $signed(DW'(r_m));
                mul_b    = r_tmp;
                mul_half = 1'b1;
            end
            OP_XX:  begin mul_a = r_npos;               mul_b = r_npos;             end
            OP_KP: begin
                mul_a    = $signed(DW'(r_k));
                mul_b    = r_tmp;
                mul_half = 1'b1;
            end
            default: begin mul_a = '0;                  mul_b = '0;                 end
        endcase
    end

    always_comb begin
        unique case (r_div_sel)
            DV_CPN:  begin div_num = r_bdt[UW-1:0]; div_den = {r_m, 1'b0}; end
            DV_CVF:  begin div_num = r_dt;          div_den = {r_m, 1'b0}; end
            DV_CVN:  begin div_num = r_b;           div_den = {1'b0, r_m}; end
            default: begin div_num = '0;            div_den = '0;          end
        endcase
    end

    // accumulate and clip after each product
    always_comb begin
        priority case (r_op)
            OP_XV:   acc_base = ACCW'(r_x);
            OP_AV:   acc_base = '0;
            default: acc_base = r_acc;
        endcase
        acc_sum = acc_base + ACCW'(mul_res);
        priority case (r_op)
            OP_PN, OP_CN: post_val = acc_sum;
            OP_KX:        post_val = -ACCW'(mul_res);
            OP_AF:        post_val = ACCW'(mul_res) + ACCW'(r_fnew);
            default:      post_val = ACCW'(mul_res);
        endcase
        post_ovf = f_ovf_acc(post_val);
        post_sat = f_sat_acc(post_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= RST_ONE;
            r_m         <= RST_ONE;
            r_a         <= RST_DAMP;
            r_b         <= RST_ONE;
            r_dt        <= RST_STEP;
            r_x0        <= '0;
            r_x         <= '0;
            r_v         <= '0;
            r_f         <= '0;
            r_cpn       <= '0;
            r_cvf       <= '0;
            r_cvn       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SPRING: r_k  <= i_cfg_data[UW-1:0];
                    CFG_MASS:   r_m  <= i_cfg_data[UW-1:0];
                    CFG_DAMP:   r_a  <= i_cfg_data[AW-1:0];
                    CFG_NOISE:  r_b  <= i_cfg_data[UW-1:0];
                    CFG_STEP:   r_dt <= i_cfg_data[UW-1:0];
                    CFG_START:  r_x0 <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (s_accept && i_s_axis_tuser[0]) begin
                r_x <= r_x0;
                r_v <= '0;
                r_f <= '0;
            end
            if (r_state == ST_DIV_WAIT && div_res.done) begin
                unique case (r_div_sel)
                    DV_CPN:  r_cpn <= div_res.quo;
                    DV_CVF:  r_cvf <= div_res.quo;
                    DV_CVN:  r_cvn <= div_res.quo;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_x <= r_npos;
                r_v <= r_nvel;
                r_f <= r_fnew;
            end
            priority if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_noise   <= i_s_axis_tdata;
            r_start   <= i_s_axis_tuser[0];
            r_clip    <= 1'b0;
            r_op      <= OP_BDT;
            r_div_sel <= DV_CPN;
        end
        if (r_state == ST_DIV_WAIT && div_res.done) begin
            r_clip    <= r_clip | div_res.clip;
            r_div_sel <= t_div_sel'(r_div_sel + 1'b1);
        end
        if (r_state == ST_POST) begin
            r_clip <= r_clip | mul_clip | post_ovf;
            r_op   <= t_op'(r_op + 1'b1);
            unique case (r_op)
                OP_BDT:                     r_bdt  <= post_sat;
                OP_CD, OP_AF, OP_VV, OP_XX: r_tmp  <= post_sat;
                OP_XV, OP_TF, OP_AV, OP_CI: r_acc  <= acc_sum;
                OP_PN:                      r_npos <= post_sat;
                OP_KX:                      r_fnew <= post_sat;
                OP_CN:                      r_nvel <= post_sat;
                OP_MK:                      r_ke   <= post_sat;
                OP_KP:                      r_pe   <= post_sat;
                default:                    ;
            endcase
        end
        if (out_load) begin
            r_out_data <= OUT_TW'({r_pe[UW-1:0], r_ke[UW-1:0], r_nvel, r_fnew, r_x});
            r_out_sat  <= r_clip;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_sat;

endmodule

/* sv/lhs_mul.sv */
module lhs_mul import lhs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_half,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_res,
    output logic                 o_clip
);

    localparam int PW = 2 * DW + 1;
    localparam logic signed [PW-1:0] RND_Q = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] RND_H = PW'(1) << FRAC_BITS;

    logic signed [2*DW-1:0] r_prod;
    logic                   r_half;
    logic signed [PW-1:0]   sum;
    logic signed [PW-1:0]   shv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_half <= i_half;
        end
    end

    // round to nearest, ties up, then clip to 32 bits
    always_comb begin
        sum    = PW'(r_prod) + (r_half ? RND_H : RND_Q);
        shv    = r_half ? (sum >>> (FRAC_BITS + 1)) : (sum >>> FRAC_BITS);
        o_clip = shv[PW-1:DW-1] != {(PW-DW+1){shv[DW-1]}};
        if (o_clip) begin
            o_res = shv[PW-1] ? S_MIN : S_MAX;
        end else begin
            o_res = shv[DW-1:0];
        end
    end

endmodule

/* sv/lhs_div.sv */
module lhs_div import lhs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [UW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output t_div_res      o_res
);

    localparam int CW = $clog2(NUMW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [NUMW-1:0] r_dvd;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic            r_den_zero;
    logic            r_num_zero;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    assign trial = {r_rem, r_dvd[NUMW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUMW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle into the dividend shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd      <= (NUMW'(i_num) << FRAC_BITS) + NUMW'(i_den >> 1);
            r_rem      <= '0;
            r_den      <= i_den;
            r_den_zero <= (i_den == '0);
            r_num_zero <= (i_num == '0);
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_dvd <= {r_dvd[NUMW-2:0], fits};
        end
    end

    always_comb begin
        o_res.done = r_done;
        if (r_den_zero) begin
            o_res.clip = 1'b1;
            o_res.quo  = r_num_zero ? '0 : S_MAX;
        end else if (|r_dvd[NUMW-1:DW-1]) begin
            o_res.clip = 1'b1;
            o_res.quo  = S_MAX;
        end else begin
            o_res.clip = 1'b0;
            o_res.quo  = {1'b0, r_dvd[DW-2:0]};
        end
    end

endmodule
